[rtl/core/dtpb_pkg.sv]
// Package for the drop-tail packet buffer timing block.
// Holds sizes, payload and RAM request types, register codes and helper functions.
// No dependencies; every module of the block imports it.
`default_nettype none

package dtpb_pkg;

    // Queue and time sizes
    localparam int MAX_DEPTH = 64;
    localparam int PTR_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int TIME_W    = 32;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_W-1:0]     CAP_RESET    = 7'd64;

    typedef struct packed {
        logic [TIME_W-1:0] arrive_time;
        logic [TIME_W-1:0] service_time;
    } in_item_t;

    typedef struct packed {
        logic              dropped;
        logic [TIME_W-1:0] launch_time;
    } out_item_t;

    // One write port and one read port of the finish-time RAM
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [TIME_W-1:0] wr_data;
        logic [PTR_W-1:0]  rd_addr;
    } ram_req_t;

    // Advance a ring pointer with wrap at the queue depth
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(MAX_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    // Add two times, saturating at the largest time
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/dtpb_time_ram.sv]
// Finish-time RAM of the drop-tail packet buffer: one write and one read port.
// Read data is registered. Depends on dtpb_pkg.
`default_nettype none

module dtpb_time_ram
    import dtpb_pkg::*;
(
    input  wire logic              aclk,
    input  wire ram_req_t          ram_req,
    output logic [TIME_W-1:0]      rd_data
);

    logic [TIME_W-1:0] mem [MAX_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    // Write the pushed finish time
    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
    end

    // Read every cycle at the requested address
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[ram_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/dtpb_apb_regs.sv]
// APB register file of the drop-tail packet buffer: holds the capacity register.
// Depends on dtpb_pkg.
`default_nettype none

module dtpb_apb_regs
    import dtpb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    output logic [CFG_W-1:0]        capacity
);

    logic [CFG_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_req;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_req  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Capture capacity on the access cycle of a write request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (wr_req && (reg_idx == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Return the addressed register
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY) begin
            prdata = {{(PDATA_W - CFG_W){1'b0}}, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

[rtl/core/drop_tail_packet_buffer_timing.sv]
// Top level of the drop-tail packet buffer timing block.
// Depends on dtpb_pkg, dtpb_time_ram and dtpb_apb_regs.
//
// Usage:
//   s_* carries one packet request (arrival and service time) per handshake;
//   m_* returns one result per packet: a drop flag and the start time.
//   The user must write the capacity register (offset 0) over the APB port only
//   while the block idles; the block itself does not enforce this.
// Operation:
//   After acceptance a packet retires each queued finish time not later than its
//   arrival, then its result is loaded; each retire step is one read of the
//   finish-time RAM (registered read data) and a compare. One packet is worked
//   on at a time: no new packet is accepted until the running one finishes.
// Reset:
//   aresetn (synchronous, active low) empties the queue, clears the output
//   valid flag and sets capacity to 64. The RAM contents need no clearing.
// Stall:
//   The result sits in an output register; a new packet is accepted while it
//   waits. A finished packet holds its state update until that register frees.
`default_nettype none

module drop_tail_packet_buffer_timing
    import dtpb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Packet input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    // Result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    // Configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] last_finish_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [CFG_W-1:0]  capacity;
    logic [CNT_W-1:0]  limit;
    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] launch_time;
    logic [TIME_W-1:0] finish_time;
    ram_req_t          ram_req;
    logic              s_accept;
    logic              pop;
    logic              out_free;
    logic              finish;
    logic              full;
    logic              push;

    dtpb_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    dtpb_time_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    // Decide the step of the running packet
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign pop      = (state_reg == ST_RUN) && (count_reg != '0)
                      && (rd_data <= item_reg.arrive_time);
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_RUN) && !pop && out_free;
    assign limit    = (capacity > CFG_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : CNT_W'(capacity);
    assign full     = (count_reg >= limit);
    assign push     = finish && !full;

    // Start after the last queued packet, or at arrival on an empty queue
    assign launch_time = (count_reg == '0) ? item_reg.arrive_time : last_finish_reg;
    assign finish_time = sat_add(launch_time, item_reg.service_time);

    // Read the next head every cycle; write the pushed finish time at the tail
    always_comb begin
        head_next = pop ? next_ptr(head_reg) : head_reg;
        tail_next = push ? next_ptr(tail_reg) : tail_reg;
        count_next = count_reg;
        if (pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (push) begin
            count_next = count_reg + CNT_W'(1);
        end
        ram_req.wr_en   = push;
        ram_req.wr_addr = tail_reg;
        ram_req.wr_data = finish_time;
        ram_req.rd_addr = head_next;
    end

    // Sequence and output register
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    state_next              = ST_IDLE;
                    m_valid_next            = 1'b1;
                    m_data_next.dropped     = full;
                    m_data_next.launch_time = full ? '0 : launch_time;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (push) begin
            last_finish_reg <= finish_time;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Queue never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DEPTH))
        else $error("finish-time queue count exceeds depth");

    // Pointers and count agree
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_W'(tail_reg - head_reg) == count_reg[PTR_W-1:0])
        else $error("head/tail pointers disagree with count");

    // A push only happens below the capacity limit
    a_push_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < limit))
        else $error("push into a full queue");

    // Pop and push never coincide
    a_pop_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && push))
        else $error("pop and push in the same cycle");

    // An accepted packet always enters the run state
    a_accept_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_RUN))
        else $error("accepted packet did not start");
`endif

endmodule

`default_nettype wire
